/* sv/brd_pkg.sv */
// Shared types and constants for the boolean range decoder.
// Used by brd_bit_unit and boolean_range_decoder; no dependencies.
package brd_pkg;

  localparam int unsigned MAX_BYTES_DEF   = 4096;
  localparam int unsigned RESULT_BITS_DEF = 32;

  // Stream widths: input 24 bits (3 bytes), output 34 bits padded to 40
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [7:0] RANGE_INIT = 8'd255;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_START  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HI,
    ST_LO,
    ST_DECIDE,
    ST_NORM,
    ST_FETCH,
    ST_DONE
  } state_e;

  typedef enum logic {
    UNIT_DECIDE,
    UNIT_SHIFT
  } unit_op_e;

  typedef struct packed {
    unit_op_e   op;
    logic [7:0] prob;
    logic       in_bit;
  } unit_req_t;

  typedef struct packed {
    logic [7:0]  range;
    logic [15:0] window;
    logic        bit_val;
  } unit_rsp_t;

endpackage

/* sv/boolean_range_decoder.sv */
// Boolean range decoder (VP8 style). Requests carry an op: clear the byte
// store, append a byte, start decoding, or read up to RESULT_BITS bits at one
// probability. Each request returns one result. One request is in work at a
// time; a result may wait on the output while the next request is taken.
// Start reads two bytes from the byte store into the window. A read of n
// bits does, per bit, one decision in the shared bit unit, a check that finds
// the range normalized, and one normalization shift per missing range bit
// (up to 7 per bit), with a byte fetched from the store for every 8 stream
// bits shifted in (zero padding past the loaded bytes needs no fetch).
// The byte store is a single RAM with a registered read port; no clearing
// pass is needed. Depends on brd_pkg, brd_ram, brd_bit_unit.
module boolean_range_decoder #(
  parameter int unsigned MAX_BYTES   = brd_pkg::MAX_BYTES_DEF,
  parameter int unsigned RESULT_BITS = brd_pkg::RESULT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [1:0] op, [9:2] stream_byte, [17:10] prob, [23:18] count
  input  logic [brd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] decoded_bits, [32] stream_exhausted, [33] store_full, rest zero
  output logic [brd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import brd_pkg::*;

  localparam int unsigned AW   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned LW   = $clog2(MAX_BYTES + 1);
  localparam int unsigned CW0  = $clog2(RESULT_BITS + 1);
  localparam int unsigned CntW = (CW0 > 6) ? CW0 : 6;

  state_e          state_q, state_d;
  logic [LW-1:0]   len_q, len_d;
  logic [LW-1:0]   pos_q, pos_d;
  logic [2:0]      bitpos_q, bitpos_d;
  logic [7:0]      range_q, range_d;
  logic [15:0]     window_q, window_d;
  logic [7:0]      cache_q, cache_d;
  logic            cache_vld_q, cache_vld_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [7:0]      prob_q, prob_d;
  logic [31:0]     bits_q, bits_d;
  logic            full_q, full_d;

  logic            m_valid_q, m_valid_d;
  logic [31:0]     out_bits_q, out_bits_d;
  logic            out_exh_q, out_exh_d;
  logic            out_full_q, out_full_d;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;

  unit_req_t       unit_req;
  unit_rsp_t       unit_rsp;

  op_e             in_op;
  logic [7:0]      in_byte;
  logic [7:0]      in_prob;
  logic [CntW-1:0] in_cnt;
  logic            accept;
  logic            store_full_now;
  logic            stream_empty;

  assign in_op   = op_e'(s_axis_tdata[1:0]);
  assign in_byte = s_axis_tdata[9:2];
  assign in_prob = s_axis_tdata[17:10];
  assign in_cnt  = CntW'(s_axis_tdata[23:18]);

  assign s_axis_tready  = (state_q == ST_IDLE);
  assign accept         = s_axis_tvalid && s_axis_tready;
  assign store_full_now = (len_q == LW'(MAX_BYTES));
  assign stream_empty   = (pos_q >= len_q);

  assign ram_we = accept && (in_op == OP_APPEND) && !store_full_now;

  brd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(len_q[AW-1:0]),
    .wdata_i(in_byte),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  brd_bit_unit u_bit_unit (
    .req_i   (unit_req),
    .range_i (range_q),
    .window_i(window_q),
    .rsp_o   (unit_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      pos_q       <= LW'(2);
      bitpos_q    <= '0;
      range_q     <= RANGE_INIT;
      window_q    <= '0;
      cache_vld_q <= 1'b0;
      rem_q       <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      bitpos_q    <= bitpos_d;
      range_q     <= range_d;
      window_q    <= window_d;
      cache_vld_q <= cache_vld_d;
      rem_q       <= rem_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cache_q    <= cache_d;
    prob_q     <= prob_d;
    bits_q     <= bits_d;
    full_q     <= full_d;
    out_bits_q <= out_bits_d;
    out_exh_q  <= out_exh_d;
    out_full_q <= out_full_d;
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    pos_d       = pos_q;
    bitpos_d    = bitpos_q;
    range_d     = range_q;
    window_d    = window_q;
    cache_d     = cache_q;
    cache_vld_d = cache_vld_q;
    rem_d       = rem_q;
    prob_d      = prob_q;
    bits_d      = bits_q;
    full_d      = full_q;
    m_valid_d   = m_valid_q;
    out_bits_d  = out_bits_q;
    out_exh_d   = out_exh_q;
    out_full_d  = out_full_q;
    ram_re      = 1'b0;
    ram_raddr   = pos_q[AW-1:0];
    unit_req    = '{op: UNIT_SHIFT, prob: prob_q, in_bit: 1'b0};

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          bits_d = '0;
          full_d = 1'b0;
          rem_d  = '0;
          prob_d = in_prob;
          state_d = ST_DONE;
          if (in_op != OP_READ) begin
            cache_vld_d = 1'b0;
          end
          case (in_op)
            OP_CLEAR: begin
              len_d = '0;
            end
            OP_APPEND: begin
              if (store_full_now) begin
                full_d = 1'b1;
              end else begin
                len_d = len_q + LW'(1);
              end
            end
            OP_START: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              range_d   = RANGE_INIT;
              pos_d     = LW'(2);
              bitpos_d  = '0;
              state_d   = ST_HI;
            end
            OP_READ: begin
              if (in_cnt > CntW'(RESULT_BITS)) begin
                rem_d = CntW'(RESULT_BITS);
              end else begin
                rem_d = in_cnt;
              end
              if (in_cnt != '0) begin
                state_d = ST_DECIDE;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_HI: begin
        window_d[15:8] = (len_q != '0) ? ram_rdata : 8'h00;
        ram_re         = 1'b1;
        ram_raddr      = AW'(1);
        state_d        = ST_LO;
      end
      ST_LO: begin
        window_d[7:0] = (len_q >= LW'(2)) ? ram_rdata : 8'h00;
        state_d       = ST_DONE;
      end
      ST_DECIDE: begin
        unit_req.op = UNIT_DECIDE;
        range_d     = unit_rsp.range;
        window_d    = unit_rsp.window;
        bits_d      = {bits_q[30:0], unit_rsp.bit_val};
        rem_d       = rem_q - CntW'(1);
        state_d     = ST_NORM;
      end
      ST_NORM: begin
        if (range_q[7]) begin
          state_d = (rem_q == '0) ? ST_DONE : ST_DECIDE;
        end else if (stream_empty) begin
          // past the loaded bytes: pad with zeros, position holds
          range_d  = unit_rsp.range;
          window_d = unit_rsp.window;
        end else if (cache_vld_q) begin
          unit_req.in_bit = cache_q[3'd7 - bitpos_q];
          range_d  = unit_rsp.range;
          window_d = unit_rsp.window;
          bitpos_d = bitpos_q + 3'd1;
          if (bitpos_q == 3'd7) begin
            pos_d       = pos_q + LW'(1);
            cache_vld_d = 1'b0;
          end
        end else begin
          ram_re  = 1'b1;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cache_d     = ram_rdata;
        cache_vld_d = 1'b1;
        state_d     = ST_NORM;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          out_bits_d = bits_q;
          out_exh_d  = stream_empty;
          out_full_d = full_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, out_full_q, out_exh_q, out_bits_q};

  // range is always normalized between requests
  a_range_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> range_q[7])
    else $error("range not normalized at idle");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(MAX_BYTES))
    else $error("loaded length beyond store depth");

  // every requested bit is decoded before the result is formed
  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> rem_q == '0)
    else $error("result formed with bits outstanding");

  // a fetched byte is only consumed from a position inside the stream
  a_fetch_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FETCH |-> pos_q < len_q)
    else $error("store fetch past loaded length");

endmodule

/* sv/brd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/brd_bit_unit.sv */
// Shared arithmetic unit of the decoder: one bit decision (split, compare,
// subtract) or one normalization shift. Depends on brd_pkg.
module brd_bit_unit (
  input  brd_pkg::unit_req_t req_i,
  input  logic [7:0]         range_i,
  input  logic [15:0]        window_i,
  output brd_pkg::unit_rsp_t rsp_o
);
  import brd_pkg::*;

  logic [15:0] prod;
  logic [7:0]  split;
  logic [15:0] big;

  // split = 1 + ((range - 1) * prob) >> 8, never above range - 1
  assign prod  = 16'(range_i - 8'd1) * 16'(req_i.prob);
  assign split = 8'd1 + prod[15:8];
  assign big   = {split, 8'h00};

  always_comb begin
    rsp_o = '0;
    case (req_i.op)
      UNIT_DECIDE: begin
        if (window_i >= big) begin
          rsp_o.range   = range_i - split;
          rsp_o.window  = window_i - big;
          rsp_o.bit_val = 1'b1;
        end else begin
          rsp_o.range   = split;
          rsp_o.window  = window_i;
          rsp_o.bit_val = 1'b0;
        end
      end
      UNIT_SHIFT: begin
        rsp_o.range   = {range_i[6:0], 1'b0};
        rsp_o.window  = {window_i[14:0], req_i.in_bit};
        rsp_o.bit_val = 1'b0;
      end
      default: begin
        rsp_o = '0;
      end
    endcase
  end

endmodule
